### rtl/drd_pkg.sv
// ----------------------------------------------------------------------------
// drd_pkg: shared types and constants for the display resize debouncer
// Payload structs, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package drd_pkg;

	// Poll counter wraps after this many polls
	localparam int unsigned POLL_PERIOD = 64;
	localparam int unsigned POLL_W      = (POLL_PERIOD > 1) ? $clog2(POLL_PERIOD) : 1;

	localparam int unsigned DIM_W   = 16;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned IDX_W   = 8;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_ADAPTIVE_ENABLE = 8'd0;
	localparam logic [IDX_W-1:0] REG_MAX_WIDTH       = 8'd1;
	localparam logic [IDX_W-1:0] REG_MAX_HEIGHT      = 8'd2;
	localparam logic [IDX_W-1:0] REG_DEFAULT_WIDTH   = 8'd3;
	localparam logic [IDX_W-1:0] REG_DEFAULT_HEIGHT  = 8'd4;
	localparam logic [IDX_W-1:0] REG_STABLE_POLLS    = 8'd5;

	// Register reset values
	localparam logic [DIM_W-1:0]   RST_MAX_WIDTH      = 16'd4096;
	localparam logic [DIM_W-1:0]   RST_MAX_HEIGHT     = 16'd2160;
	localparam logic [DIM_W-1:0]   RST_DEFAULT_WIDTH  = 16'd1024;
	localparam logic [DIM_W-1:0]   RST_DEFAULT_HEIGHT = 16'd768;
	localparam logic [COUNT_W-1:0] RST_STABLE_POLLS   = 4'd3;

	typedef struct packed {
		logic             change_event;
		logic             isr_config_bit;
		logic             query_ok;
		logic             display_on;
		logic [DIM_W-1:0] reply_width;
		logic [DIM_W-1:0] reply_height;
		logic             apply_ok;
	} poll_in_t;

	typedef struct packed {
		logic             event_ack;
		logic             query_made;
		logic             resize_request;
		logic [DIM_W-1:0] target_width;
		logic [DIM_W-1:0] target_height;
		logic [DIM_W-1:0] shown_width;
		logic [DIM_W-1:0] shown_height;
	} poll_out_t;

endpackage

`default_nettype wire

### rtl/display_resize_debouncer_core.sv
// ----------------------------------------------------------------------------
// display_resize_debouncer_core: poll-driven display size tracker
// Queries the display size on events, ISR bit or poll wrap, clamps it and
// requests a resize once a new size has been stable for enough polls.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_data  (drd_pkg::poll_in_t)
//  out     | output    | out_valid / out_ready | out_data (drd_pkg::poll_out_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One poll request per cycle unless out stalls; a request passes the input
//  register, then the result register. State is updated, in adaptive mode,
//  as a request leaves the input register. A stall on out holds the result
//  and, once the input register is also full, drops in_ready. cfg_ready is
//  always high. Reset restores register defaults, clears all tracking state.
// ----------------------------------------------------------------------------
`default_nettype none

module display_resize_debouncer_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  drd_pkg::poll_in_t            in_data,
	output logic                               out_valid,
	input  wire                                out_ready,
	output drd_pkg::poll_out_t                 out_data,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [drd_pkg::IDX_W-1:0]          cfg_index,
	input  wire  [drd_pkg::DIM_W-1:0]          cfg_data
);

	// Configuration registers
	logic                          adaptive_enable_q;
	logic [drd_pkg::DIM_W-1:0]     max_width_q, max_height_q;
	logic [drd_pkg::DIM_W-1:0]     default_width_q, default_height_q;
	logic [drd_pkg::COUNT_W-1:0]   stable_polls_q;

	// Tracking state
	logic [drd_pkg::DIM_W-1:0]     applied_width_q, applied_height_q;
	logic [drd_pkg::DIM_W-1:0]     candidate_width_q, candidate_height_q;
	logic [drd_pkg::COUNT_W-1:0]   match_count_q;
	logic [drd_pkg::POLL_W-1:0]    poll_count_q;

	// Input stage
	logic                          valid_s1;
	drd_pkg::poll_in_t             data_s1;

	// Next-state and result logic
	logic                          advance;
	logic [drd_pkg::POLL_W-1:0]    poll_next;
	logic [drd_pkg::DIM_W-1:0]     w_sel, h_sel, w_clamp, h_clamp;
	logic [drd_pkg::DIM_W-1:0]     applied_w_nx, applied_h_nx, cand_w_nx, cand_h_nx;
	logic [drd_pkg::COUNT_W-1:0]   match_nx;
	logic                          query;
	drd_pkg::poll_out_t            result;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adaptive_enable_q <= 1'b1;
			max_width_q       <= drd_pkg::RST_MAX_WIDTH;
			max_height_q      <= drd_pkg::RST_MAX_HEIGHT;
			default_width_q   <= drd_pkg::RST_DEFAULT_WIDTH;
			default_height_q  <= drd_pkg::RST_DEFAULT_HEIGHT;
			stable_polls_q    <= drd_pkg::RST_STABLE_POLLS;
		end else if (cfg_valid) begin
			case (cfg_index)
				drd_pkg::REG_ADAPTIVE_ENABLE: adaptive_enable_q <= cfg_data[0];
				drd_pkg::REG_MAX_WIDTH:       max_width_q       <= cfg_data;
				drd_pkg::REG_MAX_HEIGHT:      max_height_q      <= cfg_data;
				drd_pkg::REG_DEFAULT_WIDTH:   default_width_q   <= cfg_data;
				drd_pkg::REG_DEFAULT_HEIGHT:  default_height_q  <= cfg_data;
				drd_pkg::REG_STABLE_POLLS:    stable_polls_q    <= cfg_data[drd_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// Poll counter wrap
	always_comb begin
		if (poll_count_q == drd_pkg::POLL_W'(drd_pkg::POLL_PERIOD - 1)) begin
			poll_next = '0;
		end else begin
			poll_next = poll_count_q + 1'b1;
		end
	end

	// Fallback to default size, then clamp
	always_comb begin
		if (!data_s1.display_on || data_s1.reply_width == '0 || data_s1.reply_height == '0) begin
			w_sel = default_width_q;
			h_sel = default_height_q;
		end else begin
			w_sel = data_s1.reply_width;
			h_sel = data_s1.reply_height;
		end
		w_clamp = (w_sel > max_width_q)  ? max_width_q  : w_sel;
		h_clamp = (h_sel > max_height_q) ? max_height_q : h_sel;
	end

	// Staging of the candidate size and the result
	always_comb begin
		applied_w_nx = applied_width_q;
		applied_h_nx = applied_height_q;
		cand_w_nx    = candidate_width_q;
		cand_h_nx    = candidate_height_q;
		match_nx     = match_count_q;
		query        = data_s1.change_event || data_s1.isr_config_bit || poll_next == '0;
		result       = '0;

		if (adaptive_enable_q) begin
			result.event_ack  = data_s1.change_event;
			result.query_made = query;
			if (query && data_s1.query_ok) begin
				if (w_clamp == applied_width_q && h_clamp == applied_height_q) begin
					cand_w_nx = '0;
					cand_h_nx = '0;
					match_nx  = '0;
				end else if (w_clamp != candidate_width_q || h_clamp != candidate_height_q) begin
					cand_w_nx = w_clamp;
					cand_h_nx = h_clamp;
					match_nx  = drd_pkg::COUNT_W'(1);
				end else if (match_count_q < stable_polls_q) begin
					match_nx = match_count_q + 1'b1;
				end else begin
					result.resize_request = 1'b1;
					result.target_width   = w_clamp;
					result.target_height  = h_clamp;
					if (data_s1.apply_ok) begin
						applied_w_nx = w_clamp;
						applied_h_nx = h_clamp;
						cand_w_nx    = '0;
						cand_h_nx    = '0;
						match_nx     = '0;
					end
				end
			end
		end
		result.shown_width  = applied_w_nx;
		result.shown_height = applied_h_nx;
	end

	// State update as a request leaves the input stage, in adaptive mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			applied_width_q    <= '0;
			applied_height_q   <= '0;
			candidate_width_q  <= '0;
			candidate_height_q <= '0;
			match_count_q      <= '0;
			poll_count_q       <= '0;
		end else if (advance && adaptive_enable_q) begin
			applied_width_q    <= applied_w_nx;
			applied_height_q   <= applied_h_nx;
			candidate_width_q  <= cand_w_nx;
			candidate_height_q <= cand_h_nx;
			match_count_q      <= match_nx;
			poll_count_q       <= poll_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= result;
		end
	end

	// Checks
	a_req_needs_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.resize_request |-> out_data.query_made)
		else $error("resize requested without a query");

	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.resize_request |->
			out_data.target_width == '0 && out_data.target_height == '0)
		else $error("target size set without a resize request");

	a_ack_needs_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_ack |-> out_data.query_made)
		else $error("event acknowledged without a query");

	a_candidate_clear: assert property (@(posedge clk) disable iff (!arst_n)
		match_count_q == '0 |-> candidate_width_q == '0 && candidate_height_q == '0)
		else $error("candidate held with zero match count");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

### dv/display_resize_debouncer_core_tb.sv
// ----------------------------------------------------------------------------
// display_resize_debouncer_core_tb: self-checking bench for the debouncer core
// Drives poll requests through the valid/ready input channel, predicts each
// outcome with a behavioural tracker of the applied and candidate sizes, and
// checks every result field in order. Directed polls cover queries, fallback,
// clamping, staging and failed resizes. Random runs repeat one size often
// enough to reach a resize, under several register settings and idling mixes.
// ----------------------------------------------------------------------------

module display_resize_debouncer_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200_000;

	// DUT connections, the inputs at known values from time zero
	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	drd_pkg::poll_in_t             in_data   = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	drd_pkg::poll_out_t            out_data;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [drd_pkg::IDX_W-1:0]     cfg_index = '0;
	logic [drd_pkg::DIM_W-1:0]     cfg_data  = '0;

	// Register copies, starting at their reset values
	logic                          set_enable  = 1'b1;
	logic [drd_pkg::DIM_W-1:0]     set_max_w   = drd_pkg::RST_MAX_WIDTH;
	logic [drd_pkg::DIM_W-1:0]     set_max_h   = drd_pkg::RST_MAX_HEIGHT;
	logic [drd_pkg::DIM_W-1:0]     set_def_w   = drd_pkg::RST_DEFAULT_WIDTH;
	logic [drd_pkg::DIM_W-1:0]     set_def_h   = drd_pkg::RST_DEFAULT_HEIGHT;
	logic [drd_pkg::COUNT_W-1:0]   set_stable  = drd_pkg::RST_STABLE_POLLS;

	// Tracked sizes and counters, starting cleared as after reset
	logic [drd_pkg::DIM_W-1:0]     applied_w   = '0;
	logic [drd_pkg::DIM_W-1:0]     applied_h   = '0;
	logic [drd_pkg::DIM_W-1:0]     cand_w      = '0;
	logic [drd_pkg::DIM_W-1:0]     cand_h      = '0;
	logic [drd_pkg::COUNT_W-1:0]   match_cnt   = '0;
	int unsigned                   poll_ctr    = 0;

	drd_pkg::poll_out_t            pending_outcomes[$];
	logic [drd_pkg::DIM_W-1:0]     size_pool_w[4];
	logic [drd_pkg::DIM_W-1:0]     size_pool_h[4];

	int unsigned          send_idle_pct = 0;
	int unsigned          stall_pct     = 0;
	int unsigned          cycle_count   = 0;
	int unsigned          error_count   = 0;
	int unsigned          polls_sent    = 0;
	int unsigned          queries_seen  = 0;
	int unsigned          resizes_seen  = 0;
	int unsigned          settings_used = 1;

	display_resize_debouncer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock
	initial begin
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("[display_resize_debouncer_core] ERROR");
		$finish;
	end

	// Outcome of one poll; advances the tracked state
	function automatic drd_pkg::poll_out_t track_poll(input drd_pkg::poll_in_t p);
		drd_pkg::poll_out_t        r;
		logic [drd_pkg::DIM_W-1:0] w;
		logic [drd_pkg::DIM_W-1:0] h;
		r = '0;
		if (set_enable) begin
			r.event_ack = p.change_event;
			poll_ctr = (poll_ctr + 1) % drd_pkg::POLL_PERIOD;
			if (p.change_event || p.isr_config_bit || poll_ctr == 0) begin
				r.query_made = 1'b1;
				if (p.query_ok) begin
					w = p.reply_width;
					h = p.reply_height;
					// disabled display or zero dimension: fall back, then clamp
					if (!p.display_on || w == 0 || h == 0) begin
						w = set_def_w;
						h = set_def_h;
					end
					if (w > set_max_w) w = set_max_w;
					if (h > set_max_h) h = set_max_h;
					if (w == applied_w && h == applied_h) begin
						cand_w    = '0;
						cand_h    = '0;
						match_cnt = '0;
					end else if (w != cand_w || h != cand_h) begin
						cand_w    = w;
						cand_h    = h;
						match_cnt = drd_pkg::COUNT_W'(1);
					end else if (match_cnt < set_stable) begin
						match_cnt = match_cnt + 1'b1;
					end else begin
						r.resize_request = 1'b1;
						r.target_width   = w;
						r.target_height  = h;
						// a failed resize keeps the candidate for a retry
						if (p.apply_ok) begin
							applied_w = w;
							applied_h = h;
							cand_w    = '0;
							cand_h    = '0;
							match_cnt = '0;
						end
					end
				end
			end
		end
		r.shown_width  = applied_w;
		r.shown_height = applied_h;
		return r;
	endfunction

	function automatic drd_pkg::poll_in_t mk_poll(input bit ev, input bit isr, input bit qok,
			input bit on, input logic [drd_pkg::DIM_W-1:0] w,
			input logic [drd_pkg::DIM_W-1:0] h, input bit aok);
		drd_pkg::poll_in_t p;
		p.change_event   = ev;
		p.isr_config_bit = isr;
		p.query_ok       = qok;
		p.display_on     = on;
		p.reply_width    = w;
		p.reply_height   = h;
		p.apply_ok       = aok;
		return p;
	endfunction

	function automatic drd_pkg::poll_in_t rand_poll();
		return mk_poll(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), drd_pkg::DIM_W'($urandom_range(65535)),
			drd_pkg::DIM_W'($urandom_range(65535)), 1'($urandom_range(1)));
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	// Send one poll request and record its predicted outcome
	task automatic send_poll(input drd_pkg::poll_in_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (!in_ready);
		pending_outcomes.push_back(track_poll(p));
		polls_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [drd_pkg::IDX_W-1:0] idx,
			input logic [drd_pkg::DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			drd_pkg::REG_ADAPTIVE_ENABLE: set_enable = data[0];
			drd_pkg::REG_MAX_WIDTH:       set_max_w  = data;
			drd_pkg::REG_MAX_HEIGHT:      set_max_h  = data;
			drd_pkg::REG_DEFAULT_WIDTH:   set_def_w  = data;
			drd_pkg::REG_DEFAULT_HEIGHT:  set_def_h  = data;
			drd_pkg::REG_STABLE_POLLS:    set_stable = data[drd_pkg::COUNT_W-1:0];
			default: ;
		endcase
	endtask

	// Full register set, written only once the core has gone quiet
	task automatic write_settings(input logic en, input logic [drd_pkg::DIM_W-1:0] mw,
			input logic [drd_pkg::DIM_W-1:0] mh, input logic [drd_pkg::DIM_W-1:0] dw,
			input logic [drd_pkg::DIM_W-1:0] dh, input logic [drd_pkg::COUNT_W-1:0] sp);
		drain_results();
		write_reg(drd_pkg::REG_ADAPTIVE_ENABLE, drd_pkg::DIM_W'(en));
		write_reg(drd_pkg::REG_MAX_WIDTH, mw);
		write_reg(drd_pkg::REG_MAX_HEIGHT, mh);
		write_reg(drd_pkg::REG_DEFAULT_WIDTH, dw);
		write_reg(drd_pkg::REG_DEFAULT_HEIGHT, dh);
		write_reg(drd_pkg::REG_STABLE_POLLS, drd_pkg::DIM_W'(sp));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Mostly runs of one size, long enough to get through staging; rest noise
	task automatic run_poll_traffic(input int unsigned n);
		int unsigned               done;
		int unsigned               reps;
		int unsigned               kind;
		int unsigned               trig;
		logic [drd_pkg::DIM_W-1:0] w;
		logic [drd_pkg::DIM_W-1:0] h;
		logic                      on;
		done = 0;
		for (int i = 0; i < 4; i++) begin
			size_pool_w[i] = drd_pkg::DIM_W'($urandom_range(1, 4500));
			size_pool_h[i] = drd_pkg::DIM_W'($urandom_range(1, 2500));
		end
		while (done < n) begin
			if ($urandom_range(99) < 25) begin
				send_poll(rand_poll());
				done++;
			end else begin
				kind = $urandom_range(4);
				on   = 1'b1;
				case (kind)
					0, 1: begin
						trig = $urandom_range(3);
						w = size_pool_w[trig];
						h = size_pool_h[trig];
					end
					2: begin
						w = drd_pkg::DIM_W'($urandom_range(65535));
						h = drd_pkg::DIM_W'($urandom_range(65535));
					end
					3: begin
						on = 1'b0;
						w  = drd_pkg::DIM_W'($urandom_range(65535));
						h  = drd_pkg::DIM_W'($urandom_range(65535));
					end
					default: begin
						w = applied_w;
						h = applied_h;
					end
				endcase
				reps = set_stable + 1 + $urandom_range(2);
				// now and then a broken run that stops short
				if ($urandom_range(4) == 0) reps = $urandom_range(1, reps);
				for (int k = 0; k < reps; k++) begin
					trig = $urandom_range(9);
					send_poll(mk_poll(trig inside {[1:4], 8, 9}, trig >= 5,
						$urandom_range(15) != 0, on, w, h, $urandom_range(3) != 0));
					done++;
				end
			end
		end
	endtask

	// Queries, fallback, clamping, staging and failed resize at reset settings, then random traffic
	task automatic test_query_and_staging();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_poll(mk_poll(0, 0, 1, 1, 640, 480, 1));
		send_poll(mk_poll(1, 0, 0, 1, 640, 480, 1));
		send_poll(mk_poll(0, 1, 1, 0, 640, 480, 1));
		send_poll(mk_poll(1, 1, 1, 1, 0, 500, 1));
		send_poll(mk_poll(0, 1, 1, 1, 1024, 768, 0));
		send_poll(mk_poll(0, 1, 1, 1, 1024, 768, 0));
		send_poll(mk_poll(0, 1, 1, 1, 1024, 768, 1));
		send_poll(mk_poll(0, 1, 1, 1, 16'hffff, 16'hffff, 0));
		send_poll(mk_poll(1, 0, 1, 1, 5000, 3000, 0));
		send_poll(mk_poll(0, 1, 1, 1, 4096, 2160, 0));
		send_poll(mk_poll(0, 1, 1, 1, 16'hffff, 16'hffff, 1));
		send_poll(mk_poll(0, 1, 1, 1, 1024, 768, 1));
		send_poll(mk_poll(0, 1, 1, 1, 4096, 2160, 0));
		send_poll(mk_poll(1, 1, 1, 1, 16'hffff, 16'hffff, 1));
		run_poll_traffic(200);
	endtask

	// Adaptive mode off: polls leave everything untouched
	task automatic test_disabled_polls();
		write_settings(1'b0, 4096, 2160, 1024, 768, 3);
		send_poll(mk_poll(1, 1, 1, 1, 640, 480, 1));
		repeat (4) send_poll(rand_poll());
		write_settings(1'b1, 4096, 2160, 1024, 768, 3);
	endtask

	// Limits of one, defaults at the top, stable count of zero
	task automatic test_tight_limits();
		write_settings(1'b1, 1, 1, 16'hffff, 16'hffff, 0);
		send_idle_pct = 14;
		stall_pct     = 14;
		send_poll(mk_poll(0, 1, 1, 0, 0, 0, 1));
		send_poll(mk_poll(1, 0, 1, 1, 16'hffff, 16'hffff, 1));
		send_poll(mk_poll(0, 1, 1, 1, 1, 1, 1));
		run_poll_traffic(100);
	endtask

	// Full range limits, defaults of one, longest stable count
	task automatic test_wide_limits();
		write_settings(1'b1, 16'hffff, 16'hffff, 1, 1, 15);
		send_idle_pct = 81;
		stall_pct     = 0;
		run_poll_traffic(180);
	endtask

	// Fallback size larger than the limits gets clamped too
	task automatic test_limits_below_defaults();
		write_settings(1'b1, 800, 600, 1920, 1080, 1);
		send_idle_pct = 0;
		stall_pct     = 81;
		run_poll_traffic(180);
	endtask

	task automatic test_random_settings();
		send_idle_pct = 14;
		stall_pct     = 14;
		repeat (3) begin
			write_settings(1'b1, drd_pkg::DIM_W'($urandom_range(1, 5000)),
				drd_pkg::DIM_W'($urandom_range(1, 3000)),
				drd_pkg::DIM_W'($urandom_range(1, 5000)),
				drd_pkg::DIM_W'($urandom_range(1, 3000)),
				drd_pkg::COUNT_W'($urandom_range(15)));
			run_poll_traffic(60);
		end
	endtask

	// Result checker with random back-pressure
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no poll request outstanding");
				error_count++;
			end else begin
				drd_pkg::poll_out_t want;
				want = pending_outcomes.pop_front();
				check_field("event_ack", want.event_ack, out_data.event_ack);
				check_field("query_made", want.query_made, out_data.query_made);
				check_field("resize_request", want.resize_request, out_data.resize_request);
				check_field("target_width", want.target_width, out_data.target_width);
				check_field("target_height", want.target_height, out_data.target_height);
				check_field("shown_width", want.shown_width, out_data.shown_width);
				check_field("shown_height", want.shown_height, out_data.shown_height);
				queries_seen += want.query_made;
				resizes_seen += want.resize_request;
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_query_and_staging();
		test_disabled_polls();
		test_tight_limits();
		test_wide_limits();
		test_limits_below_defaults();
		test_random_settings();
		drain_results();
		repeat (4) @(posedge clk);
		if (pending_outcomes.size() != 0) begin
			$error("%0d poll results never arrived", pending_outcomes.size());
			error_count++;
		end
		$display("%0d polls under %0d register settings, %0d queries, %0d resize requests",
			polls_sent, settings_used, queries_seen, resizes_seen);
		$display("idling mixes: none, sender 81%%, receiver 81%%, both 14%%; %0d errors",
			error_count);
		if (error_count == 0) begin
			$display("[display_resize_debouncer_core] OK");
		end else begin
			$display("[display_resize_debouncer_core] ERROR");
		end
		$finish;
	end

endmodule

### files.f
rtl/drd_pkg.sv
rtl/display_resize_debouncer_core.sv
dv/display_resize_debouncer_core_tb.sv
